@@ sv/owm_pkg.sv @@
// Package for the single-wire bus master: codes, widths, timer helper and
// the structs passed between the configuration block, the core and the top level.
// No dependencies.
`default_nettype none
package owm_pkg;

  localparam int TIMER_BITS    = 12;
  localparam int BITS_PER_BYTE = 8;
  localparam int CFG_DATA_W    = 12;
  localparam int CFG_INDEX_W   = 3;
  localparam int TIMER_MAX     = (1 << TIMER_BITS) - 1;

  typedef logic [TIMER_BITS-1:0] timer_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PRES  = 2'd1,
    ST_PRES_LONG = 2'd2,
    ST_BUSY     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REL   = 4'd2,
    PH_PRES_WAIT = 4'd3,
    PH_PRES_LOW  = 4'd4,
    PH_W_LOW     = 4'd5,
    PH_W_HIGH    = 4'd6,
    PH_R_LOW     = 4'd7,
    PH_R_WAIT    = 4'd8,
    PH_R_RECOV   = 4'd9
  } phase_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESET_RELEASE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRES_WAIT     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRES_LOW      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_PULSE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PULSE    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_READ_SAMPLE   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_READ_RECOVER  = 3'd7;

  // Timing values as the core uses them: zero reads as one, and anything
  // beyond the timer range is saturated.
  typedef struct packed {
    timer_t reset_low;
    timer_t reset_release;
    timer_t pres_wait;
    timer_t pres_low;
    timer_t short_pulse;
    timer_t long_pulse;
    timer_t read_sample;
    timer_t read_recover;
  } cfg_t;

  typedef struct packed {
    logic    drive_low;
    logic    busy_res;
    logic    done_res;
    status_t status;
    logic [7:0] read_byte;
  } res_t;

  function automatic timer_t dur(input logic [CFG_DATA_W-1:0] v);
    timer_t r;
    if (v == '0) begin
      r = timer_t'(1);
    end else if (int'(v) > TIMER_MAX) begin
      r = timer_t'(TIMER_MAX);
    end else begin
      r = timer_t'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/owm_cfg.sv @@
// Configuration register file of the single-wire bus master.
// Stores each timing value already clamped for the core. Uses owm_pkg.
`default_nettype none
module owm_cfg
  import owm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  logic [CFG_DATA_W-1:0] d8;
  logic [CFG_DATA_W-1:0] d10;

  assign d8  = {4'b0, cfg_data[7:0]};
  assign d10 = {2'b0, cfg_data[9:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low     <= dur(12'd600);
      cfg.reset_release <= dur(12'd10);
      cfg.pres_wait     <= dur(12'd200);
      cfg.pres_low      <= dur(12'd240);
      cfg.short_pulse   <= dur(12'd2);
      cfg.long_pulse    <= dur(12'd60);
      cfg.read_sample   <= dur(12'd12);
      cfg.read_recover  <= dur(12'd50);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESET_LOW:     cfg.reset_low     <= dur(cfg_data);
        CFG_RESET_RELEASE: cfg.reset_release <= dur(d8);
        CFG_PRES_WAIT:     cfg.pres_wait     <= dur(d10);
        CFG_PRES_LOW:      cfg.pres_low      <= dur(d10);
        CFG_SHORT_PULSE:   cfg.short_pulse   <= dur(d8);
        CFG_LONG_PULSE:    cfg.long_pulse    <= dur(d8);
        CFG_READ_SAMPLE:   cfg.read_sample   <= dur(d8);
        CFG_READ_RECOVER:  cfg.read_recover  <= dur(d8);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/owm_core.sv @@
// Bus sequencer of the single-wire bus master: phase machine, slot timer,
// bit counter and shift register, one tick per enabled cycle. Uses owm_pkg.
`default_nettype none
module owm_core
  import owm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire cmd_t       cmd,
  input  wire logic [7:0] byte_in,
  input  wire logic       line_high,
  input  wire cfg_t       cfg,
  output res_t            res
);

  phase_t     phase, phase_next, ph_eff;
  timer_t     tick_timer, tick_timer_next, t_dec, t_inc;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic       fin;
  status_t    fst;

  always_comb begin
    phase_next      = phase;
    tick_timer_next = tick_timer;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    fin             = 1'b0;
    fst             = ST_OK;
    if (phase == PH_IDLE && cmd != CMD_NONE) begin
      bit_index_next = '0;
      case (cmd)
        CMD_RESET: begin
          phase_next      = PH_RST_LOW;
          tick_timer_next = cfg.reset_low;
        end
        CMD_WRITE: begin
          shift_byte_next = byte_in;
          phase_next      = PH_W_LOW;
          tick_timer_next = byte_in[0] ? cfg.short_pulse : cfg.long_pulse;
        end
        default: begin
          shift_byte_next = '0;
          phase_next      = PH_R_LOW;
          tick_timer_next = cfg.short_pulse;
        end
      endcase
    end
    ph_eff = phase_next;
    t_dec  = tick_timer_next - timer_t'(1);
    t_inc  = tick_timer_next + timer_t'(1);
    case (ph_eff)
      PH_IDLE: ;
      PH_RST_LOW: begin
        tick_timer_next = t_dec;
        if (t_dec == '0) begin
          phase_next      = PH_RST_REL;
          tick_timer_next = cfg.reset_release;
        end
      end
      PH_RST_REL: begin
        tick_timer_next = t_dec;
        if (t_dec == '0) begin
          phase_next = PH_PRES_WAIT;
        end
      end
      PH_PRES_WAIT: begin
        if (line_high) begin
          tick_timer_next = t_inc;
          if (t_inc >= cfg.pres_wait) begin
            fin = 1'b1;
            fst = ST_NO_PRES;
          end
        end else begin
          tick_timer_next = timer_t'(1);
          if (cfg.pres_low == timer_t'(1)) begin
            fin = 1'b1;
            fst = ST_PRES_LONG;
          end else begin
            phase_next = PH_PRES_LOW;
          end
        end
      end
      PH_PRES_LOW: begin
        if (line_high) begin
          fin = 1'b1;
        end else begin
          tick_timer_next = t_inc;
          if (t_inc >= cfg.pres_low) begin
            fin = 1'b1;
            fst = ST_PRES_LONG;
          end
        end
      end
      PH_W_LOW: begin
        tick_timer_next = t_dec;
        if (t_dec == '0) begin
          phase_next      = PH_W_HIGH;
          tick_timer_next = shift_byte_next[0] ? cfg.long_pulse : cfg.short_pulse;
        end
      end
      PH_W_HIGH: begin
        tick_timer_next = t_dec;
        if (t_dec == '0) begin
          shift_byte_next = {1'b0, shift_byte_next[7:1]};
          if (bit_index_next == 3'(BITS_PER_BYTE - 1)) begin
            fin = 1'b1;
          end else begin
            bit_index_next  = bit_index_next + 3'd1;
            phase_next      = PH_W_LOW;
            tick_timer_next = shift_byte_next[0] ? cfg.short_pulse : cfg.long_pulse;
          end
        end
      end
      PH_R_LOW: begin
        tick_timer_next = t_dec;
        if (t_dec == '0) begin
          phase_next      = PH_R_WAIT;
          tick_timer_next = cfg.read_sample;
        end
      end
      PH_R_WAIT: begin
        tick_timer_next = t_dec;
        if (t_dec == '0) begin
          shift_byte_next = {line_high, shift_byte_next[7:1]};
          phase_next      = PH_R_RECOV;
          tick_timer_next = cfg.read_recover;
        end
      end
      PH_R_RECOV: begin
        tick_timer_next = t_dec;
        if (t_dec == '0) begin
          if (bit_index_next == 3'(BITS_PER_BYTE - 1)) begin
            fin = 1'b1;
          end else begin
            bit_index_next  = bit_index_next + 3'd1;
            phase_next      = PH_R_LOW;
            tick_timer_next = cfg.short_pulse;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    if (fin) begin
      phase_next      = PH_IDLE;
      bit_index_next  = '0;
      tick_timer_next = '0;
    end
  end

  always_comb begin
    res.drive_low = (ph_eff == PH_RST_LOW) || (ph_eff == PH_W_LOW) || (ph_eff == PH_R_LOW);
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = fin;
    if (fin) begin
      res.status = fst;
    end else if (phase != PH_IDLE && cmd != CMD_NONE) begin
      res.status = ST_BUSY;
    end else begin
      res.status = ST_OK;
    end
    res.read_byte = (fin && ph_eff == PH_R_RECOV) ? shift_byte_next : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_timer <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
    end else if (en) begin
      phase      <= phase_next;
      tick_timer <= tick_timer_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
    end
  end

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(phase) && $stable(tick_timer) && $stable(shift_byte))
    else $error("sequencer state moved without an enabled tick");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res.done_res |-> !res.busy_res)
    else $error("done reported while still busy");

  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    res.drive_low |-> res.busy_res)
    else $error("bus driven low outside an operation");

  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    (en && phase == PH_IDLE && cmd == CMD_NONE) |=> phase == PH_IDLE)
    else $error("left idle without a command");

endmodule
`default_nettype wire

@@ sv/one_wire_bus_master.sv @@
// Top level of the single-wire bus master: input register, sequencer core,
// configuration registers and output register. Uses owm_pkg, owm_cfg, owm_core.
//
// Usage: feed one request per one-microsecond tick on the s_ channel. s_tuser
// carries the command (none, bus reset, write byte, read byte) and s_tdata the
// byte to write and the sampled bus level. Every request produces exactly one
// result on the m_ channel with the drive level for that tick, busy, done,
// status and the assembled read byte. A command that arrives while an
// operation runs is rejected with the busy status, or with the final status
// if the operation ends on that tick. Requests go through the input and the
// output register; one request per cycle while the receiver does not stall.
// When the receiver stalls, the result waits in the output register, one more
// request waits in the input register and s_tready drops; nothing is lost.
// Reset (synchronous, active high) empties both registers, returns the
// sequencer to idle and loads the default timing values. Configuration
// writes via cfg_we take effect at the next edge and are meant for idle times.
`default_nettype none
module one_wire_bus_master
  import owm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [15:0]            s_tdata,   // byte_in[7:0], line_high[8], zero pad
  input  wire logic [1:0]             s_tuser,   // cmd[1:0]
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [15:0]                 m_tdata,   // drive_low[0], busy_res[1], done_res[2],
                                                 // status[4:3], read_byte[12:5], zero pad
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic       in_valid;
  cmd_t       in_cmd;
  logic [7:0] in_byte;
  logic       in_line;
  logic       adv;
  cfg_t       cfg;
  res_t       res;
  res_t       out_res;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  owm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .cmd       (in_cmd),
    .byte_in   (in_byte),
    .line_high (in_line),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= cmd_t'(s_tuser);
      in_byte <= s_tdata[7:0];
      in_line <= s_tdata[8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res.read_byte, out_res.status, out_res.done_res,
                    out_res.busy_res, out_res.drive_low};

endmodule
`default_nettype wire

@@ dv/tb_one_wire_bus_master.sv @@
// Self-checking testbench for one_wire_bus_master: ticks with commands and bus levels
// go in on the request stream, and every tick result is compared with a local model.
// Depends on owm_pkg and the RTL of one_wire_bus_master.
`default_nettype none
module tb_one_wire_bus_master;
  import owm_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 300;

  typedef struct {
    logic       drive;
    logic       busy;
    logic       done;
    status_t    status;
    logic [7:0] rbyte;
  } tick_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata = '0;
  logic [1:0]             s_tuser = CMD_NONE;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [15:0]            m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic [CFG_DATA_W-1:0]  bus_timing [8];
  phase_t                 bus_phase;
  timer_t                 tick_left;
  int                     slot_bit;
  logic [7:0]             shreg;

  tick_result_t           tick_results_due[$];
  int                     errors = 0;
  int                     items_sent = 0;
  int                     quiet_cycles = 0;
  bit                     calm = 1'b0;

  one_wire_bus_master DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic timer_t as_ticks(input logic [CFG_DATA_W-1:0] v);
    return (v == '0) ? timer_t'(1) : timer_t'(v);
  endfunction

  function automatic bit count_down();
    tick_left = tick_left - 1'b1;
    return tick_left == '0;
  endfunction

  function automatic void load_write_slot();
    bus_phase = PH_W_LOW;
    tick_left = as_ticks(shreg[0] ? bus_timing[CFG_SHORT_PULSE] : bus_timing[CFG_LONG_PULSE]);
  endfunction

  function automatic void clear_bus_model();
    bus_timing[CFG_RESET_LOW]     = 12'd600;
    bus_timing[CFG_RESET_RELEASE] = 12'd10;
    bus_timing[CFG_PRES_WAIT]     = 12'd200;
    bus_timing[CFG_PRES_LOW]      = 12'd240;
    bus_timing[CFG_SHORT_PULSE]   = 12'd2;
    bus_timing[CFG_LONG_PULSE]    = 12'd60;
    bus_timing[CFG_READ_SAMPLE]   = 12'd12;
    bus_timing[CFG_READ_RECOVER]  = 12'd50;
    bus_phase = PH_IDLE;
    tick_left = '0;
    slot_bit  = 0;
    shreg     = 8'h00;
  endfunction

  function automatic tick_result_t advance_bus_tick(input cmd_t cmd, input logic [7:0] din,
                                                    input logic line);
    tick_result_t r;
    logic         fin;
    status_t      fin_status;
    r.drive = 1'b0;
    r.busy = 1'b0;
    r.done = 1'b0;
    r.status = ST_OK;
    r.rbyte = 8'h00;
    fin = 1'b0;
    fin_status = ST_OK;
    if (bus_phase != PH_IDLE) begin
      if (cmd != CMD_NONE) r.status = ST_BUSY;
    end else if (cmd != CMD_NONE) begin
      slot_bit = 0;
      case (cmd)
        CMD_RESET: begin
          bus_phase = PH_RST_LOW;
          tick_left = as_ticks(bus_timing[CFG_RESET_LOW]);
        end
        CMD_WRITE: begin
          shreg = din;
          load_write_slot();
        end
        default: begin
          shreg = 8'h00;
          bus_phase = PH_R_LOW;
          tick_left = as_ticks(bus_timing[CFG_SHORT_PULSE]);
        end
      endcase
    end
    case (bus_phase)
      PH_RST_LOW: begin
        r.drive = 1'b1;
        if (count_down()) begin
          bus_phase = PH_RST_REL;
          tick_left = as_ticks(bus_timing[CFG_RESET_RELEASE]);
        end
      end
      PH_RST_REL: begin
        if (count_down()) begin
          bus_phase = PH_PRES_WAIT;
          tick_left = '0;
        end
      end
      PH_PRES_WAIT: begin
        if (line) begin
          tick_left = tick_left + 1'b1;
          if (tick_left >= as_ticks(bus_timing[CFG_PRES_WAIT])) begin
            fin = 1'b1;
            fin_status = ST_NO_PRES;
          end
        end else begin
          tick_left = timer_t'(1);
          if (tick_left >= as_ticks(bus_timing[CFG_PRES_LOW])) begin
            fin = 1'b1;
            fin_status = ST_PRES_LONG;
          end else begin
            bus_phase = PH_PRES_LOW;
          end
        end
      end
      PH_PRES_LOW: begin
        if (line) begin
          fin = 1'b1;
        end else begin
          tick_left = tick_left + 1'b1;
          if (tick_left >= as_ticks(bus_timing[CFG_PRES_LOW])) begin
            fin = 1'b1;
            fin_status = ST_PRES_LONG;
          end
        end
      end
      PH_W_LOW: begin
        r.drive = 1'b1;
        if (count_down()) begin
          bus_phase = PH_W_HIGH;
          tick_left = as_ticks(shreg[0] ? bus_timing[CFG_LONG_PULSE]
                                        : bus_timing[CFG_SHORT_PULSE]);
        end
      end
      PH_W_HIGH: begin
        if (count_down()) begin
          shreg = shreg >> 1;
          if (slot_bit >= BITS_PER_BYTE - 1) begin
            fin = 1'b1;
          end else begin
            slot_bit++;
            load_write_slot();
          end
        end
      end
      PH_R_LOW: begin
        r.drive = 1'b1;
        if (count_down()) begin
          bus_phase = PH_R_WAIT;
          tick_left = as_ticks(bus_timing[CFG_READ_SAMPLE]);
        end
      end
      PH_R_WAIT: begin
        if (count_down()) begin
          shreg = {line, shreg[7:1]};
          bus_phase = PH_R_RECOV;
          tick_left = as_ticks(bus_timing[CFG_READ_RECOVER]);
        end
      end
      PH_R_RECOV: begin
        if (count_down()) begin
          if (slot_bit >= BITS_PER_BYTE - 1) begin
            fin = 1'b1;
            r.rbyte = shreg;
          end else begin
            slot_bit++;
            bus_phase = PH_R_LOW;
            tick_left = as_ticks(bus_timing[CFG_SHORT_PULSE]);
          end
        end
      end
      default: ;
    endcase
    if (fin) begin
      r.done = 1'b1;
      r.status = fin_status;
      bus_phase = PH_IDLE;
      slot_bit = 0;
      tick_left = '0;
    end
    r.busy = (bus_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void field_check(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (tick_results_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0h", $time, m_tdata);
        errors++;
      end else begin
        want = tick_results_due.pop_front();
        field_check("drive_low", want.drive, m_tdata[0]);
        field_check("busy_res", want.busy, m_tdata[1]);
        field_check("done_res", want.done, m_tdata[2]);
        field_check("status", want.status, m_tdata[4:3]);
        field_check("read_byte", want.rbyte, m_tdata[12:5]);
      end
    end
    m_tready <= calm || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input cmd_t cmd, input logic [7:0] din, input logic line);
    if (!calm && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {7'b0, line, din};
    do @(posedge clk); while (!s_tready);
    tick_results_due.push_back(advance_bus_tick(cmd, din, line));
    items_sent++;
  endtask

  // Sends the command, then plain ticks until the operation is over. The bus level
  // is low on about pct_low percent of the ticks; some ticks carry a stray command.
  task automatic run_op(input cmd_t cmd, input logic [7:0] din, input int pct_low,
                        input int pct_reject);
    cmd_t extra;
    send_item(cmd, din, $urandom_range(99) >= pct_low);
    while (bus_phase != PH_IDLE) begin
      extra = ($urandom_range(99) < pct_reject) ? cmd_t'($urandom_range(1, 3)) : CMD_NONE;
      send_item(extra, 8'($urandom_range(255)), $urandom_range(99) >= pct_low);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    logic [CFG_DATA_W-1:0] mask;
    case (idx)
      CFG_RESET_LOW:               mask = 12'hFFF;
      CFG_PRES_WAIT, CFG_PRES_LOW: mask = 12'h3FF;
      default:                     mask = 12'h0FF;
    endcase
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    bus_timing[idx] = v & mask;
  endtask

  task automatic apply_timing(input logic [11:0] rst_low, rst_rel, pres_wait, pres_low,
                              short_p, long_p, sample, recover);
    write_reg(CFG_RESET_LOW, rst_low);
    write_reg(CFG_RESET_RELEASE, rst_rel);
    write_reg(CFG_PRES_WAIT, pres_wait);
    write_reg(CFG_PRES_LOW, pres_low);
    write_reg(CFG_SHORT_PULSE, short_p);
    write_reg(CFG_LONG_PULSE, long_p);
    write_reg(CFG_READ_SAMPLE, sample);
    write_reg(CFG_READ_RECOVER, recover);
    cfg_we <= 1'b0;
  endtask

  task automatic test_default_timing();
    run_op(CMD_RESET, 8'h00, 50, 0);
  endtask

  task automatic test_directed();
    wait_idle();
    apply_timing(12'd2, 12'd1, 12'd3, 12'd3, 12'd1, 12'd2, 12'd2, 12'd1);
    send_item(CMD_RESET, 8'h00, 1'b1);
    while (bus_phase != PH_PRES_WAIT) send_item(CMD_NONE, 8'h00, 1'b1);
    send_item(CMD_NONE, 8'hFF, 1'b0);
    while (bus_phase != PH_IDLE) send_item(CMD_NONE, 8'h00, 1'b1);
    run_op(CMD_RESET, 8'h00, 0, 0);
    run_op(CMD_RESET, 8'hFF, 100, 0);
    run_op(CMD_WRITE, 8'h00, 50, 0);
    run_op(CMD_WRITE, 8'hFF, 50, 40);
    run_op(CMD_READ, 8'hFF, 50, 20);
    send_item(CMD_NONE, 8'hFF, 1'b0);
    send_item(CMD_NONE, 8'h00, 1'b1);
  endtask

  task automatic test_timing_extremes();
    wait_idle();
    // Upper bits set: the narrower registers keep only their low bits.
    apply_timing(12'd5, 12'hF01, 12'hC02, 12'hC03, 12'hF02, 12'hF03, 12'hF02, 12'hF01);
    run_op(CMD_RESET, 8'h00, 0, 0);
    run_op(CMD_RESET, 8'h00, 100, 0);
    run_op(CMD_WRITE, 8'h96, 50, 2);
    run_op(CMD_READ, 8'h00, 50, 2);
    wait_idle();
    apply_timing(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    run_op(CMD_RESET, 8'h00, 50, 0);
    run_op(CMD_RESET, 8'h00, 0, 0);
    run_op(CMD_WRITE, 8'h5A, 50, 30);
    run_op(CMD_READ, 8'h00, 50, 30);
  endtask

  task automatic test_random_traffic();
    int first;
    int cfg_mark;
    int pick;
    int pct_low;
    first = items_sent;
    cfg_mark = items_sent - 1000;
    while (items_sent - first < RANDOM_ITEMS) begin
      if (items_sent - cfg_mark >= 100) begin
        wait_idle();
        apply_timing(12'($urandom_range(16)), 12'($urandom_range(4)),
                     12'($urandom_range(10)), 12'($urandom_range(10)),
                     12'($urandom_range(4)), 12'($urandom_range(6)),
                     12'($urandom_range(5)), 12'($urandom_range(5)));
        cfg_mark = items_sent;
      end
      calm = (items_sent - first >= 100) && (items_sent - first < 200);
      case ($urandom_range(4))
        0:       pct_low = 0;
        1:       pct_low = 20;
        2:       pct_low = 50;
        3:       pct_low = 80;
        default: pct_low = 100;
      endcase
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_item(CMD_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        run_op(cmd_t'($urandom_range(1, 3)), 8'($urandom_range(255)), pct_low,
               (pick < 40) ? 5 : 0);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    clear_bus_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_default_timing();
    test_directed();
    test_timing_extremes();
    test_random_traffic();
    wait_idle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
